@@ rtl/core/tbrl_pkg.sv @@
// Shared widths, register indexes and types of the token bucket rate limiter.
package tbrl_pkg;

	localparam int NowW     = 64;
	localparam int IvW      = 40;
	localparam int PermW    = 32;
	localparam int ReqPermW = 16;
	localparam int TmoW     = 16;
	localparam int WaitW    = 63;
	localparam int QuoW     = 32;
	localparam int PushW    = 48;
	localparam int CfgIdxW  = 8;
	localparam int CfgDataW = 40;
	localparam int SerCntW  = $clog2(QuoW);
	localparam int FracW    = 16;   // Q16 permits
	localparam int ElapsLoW = 8;    // elapsed bits below the Q8 interval point
	localparam int TmoUsW   = 26;   // 16-bit ms times 1000

	localparam logic [CfgIdxW-1:0] REG_INTERVAL    = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] REG_MAX_PERMITS = CfgIdxW'(1);

	localparam logic [IvW-1:0]    INTERVAL_RESET = IvW'(256000000);
	localparam logic [TmoUsW-1:0] US_PER_MS      = TmoUsW'(1000);

	// status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} ser_stat_t;

endpackage

@@ rtl/core/tbrl_if.sv @@
// Request and response channel interfaces of the token bucket rate limiter.
interface tbrl_req_if import tbrl_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                action;
	logic [NowW-1:0]     now_us;
	logic [ReqPermW-1:0] permits;
	logic [TmoW-1:0]     timeout_ms;

	modport source (output valid, action, now_us, permits, timeout_ms, input ready);
	modport sink   (input valid, action, now_us, permits, timeout_ms, output ready);
endinterface

interface tbrl_resp_if import tbrl_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             granted;
	logic [WaitW-1:0] wait_us;

	modport source (output valid, granted, wait_us, input ready);
	modport sink   (input valid, granted, wait_us, output ready);
endinterface

@@ rtl/core/tbrl_div.sv @@
// Bit-serial restoring divider: floor(elapsed * 2^24 / interval), one quotient bit per cycle.
module tbrl_div import tbrl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [IvW-1:0]   rem_init,   // elapsed >> 8, already below divisor
	input  logic [ElapsLoW-1:0] low_bits, // elapsed[7:0]
	input  logic [IvW-1:0]   divisor,
	output logic [QuoW-1:0]  quo,
	output ser_stat_t        stat
);

	logic [IvW-1:0]     rem_q;
	logic [IvW-1:0]     dvs_q;
	logic [QuoW-1:0]    low_q;
	logic [QuoW-1:0]    quo_q;
	logic [SerCntW-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [IvW:0] shifted;
	logic [IvW:0] diff;
	logic         fits;

	assign shifted = {rem_q, low_q[QuoW-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign fits    = ~diff[IvW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SerCntW'(QuoW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dvs_q <= divisor;
			low_q <= {low_bits, {(QuoW-ElapsLoW){1'b0}}};
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[IvW-1:0] : shifted[IvW-1:0];
			low_q <= {low_q[QuoW-2:0], 1'b0};
			quo_q <= {quo_q[QuoW-2:0], fits};
		end
	end

	assign quo       = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

@@ rtl/core/tbrl_mul.sv @@
// Shift-add multiplier: floor(fresh * interval / 2^24), one multiplier bit per cycle.
module tbrl_mul import tbrl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PermW-1:0]  fresh,
	input  logic [IvW-1:0]    iv,
	output logic [PushW-1:0]  push,
	output ser_stat_t         stat
);

	logic [IvW-1:0]     hi_q;
	logic [PermW-1:0]   lo_q;
	logic [IvW-1:0]     b_q;
	logic [SerCntW-1:0] cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [IvW:0] sum;

	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, b_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= SerCntW'(PermW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q <= '0;
			lo_q <= fresh;
			b_q  <= iv;
		end else if (busy_q) begin
			hi_q <= sum[IvW:1];
			lo_q <= {sum[0], lo_q[PermW-1:1]};
		end
	end

	// product is {hi, lo}; drop the 24 fraction bits
	assign push      = {hi_q, lo_q[PermW-1 -: (PushW-IvW)]};
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

@@ rtl/core/token_bucket_rate_limiter.sv @@
// Top level of the token bucket rate limiter: request sequencer, bucket state, result register.
//
// Usage:
//   req  : valid/ready request channel carrying action, now_us, permits, timeout_ms.
//          action 0 acquires unconditionally, 1 tries with a timeout in ms.
//   resp : valid/ready result channel carrying granted and wait_us.
//   cfg  : write port; cfg_idx 0 sets the Q8 interval, 1 sets the Q16 capacity and
//          refills the bucket. Write only while no request is in flight.
// Flow (one request at a time): a refused try-acquire goes from the checks straight to the
//   result; with no time elapsed only the multiplier runs; an accrual with a saturated
//   quotient skips the divider; any other accrual runs the divider, then the multiplier.
//   Divider and multiplier each work one bit per cycle. The next request can be taken in
//   the cycle after the result is written; none is taken while one is in flight.
// Reset: interval returns to 1 s (256000000 in Q8), capacity, stored permits and
//   next free time clear to zero.
// Stall: the result sits in an output register; a new request is taken while it
//   waits, but that request's result holds in the final step until the register frees.
module token_bucket_rate_limiter import tbrl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_data,
	tbrl_req_if.sink            req,
	tbrl_resp_if.source         resp
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_CHECK = 9'b000000010,  // deadline, elapsed, time-past flag
		S_DEC   = 9'b000000100,  // refuse or choose accrual path
		S_ACCR  = 9'b000001000,  // saturation test, launch divider
		S_DIV   = 9'b000010000,
		S_UPD   = 9'b000100000,  // add accrued permits, clamp to capacity
		S_SPEND = 9'b001000000,  // wait, spend, launch multiplier
		S_MUL   = 9'b010000000,
		S_FIN   = 9'b100000000   // push next free time and spend unless refused, write result
	} state_t;

	state_t state_q;

	// bucket state and configuration
	logic [IvW-1:0]   interval_q;
	logic [PermW-1:0] max_q;
	logic [PermW-1:0] stored_q;
	logic [NowW-1:0]  nft_q;

	// request context
	logic                action_q;
	logic [NowW-1:0]     now_q;
	logic [ReqPermW-1:0] want_q;
	logic [TmoW-1:0]     tmo_q;
	logic [NowW-1:0]     deadline_q;
	logic [NowW-1:0]     elapsed_q;
	logic                past_q;
	logic                sat_q;
	logic                refused_q;
	logic [PermW-1:0]    spend_q;
	logic [WaitW-1:0]    wait_q;

	// result register
	logic             resp_valid_q;
	logic             granted_q;
	logic [WaitW-1:0] wait_us_q;

	// datapath
	logic [IvW-1:0]    iv_eff;
	logic [TmoUsW-1:0] tmo_us;
	logic [NowW:0]     dl_sum;
	logic [NowW-1:0]   deadline;
	logic              sat;
	logic [PermW-1:0]  add;
	logic [PermW:0]    acc_sum;
	logic [PermW-1:0]  want_q16;
	logic [PermW-1:0]  spend;
	logic [PermW-1:0]  fresh;
	logic [NowW-1:0]   ahead;
	logic [WaitW-1:0]  wait_sat;
	logic [NowW:0]     nft_sum;
	logic              accept;
	logic              fin_go;
	logic              div_start;
	logic              mul_start;
	logic [QuoW-1:0]   quo;
	logic [PushW-1:0]  push;
	ser_stat_t         div_stat;
	ser_stat_t         mul_stat;

	// zero interval behaves as the smallest step
	assign iv_eff = (interval_q == '0) ? IvW'(1) : interval_q;

	assign tmo_us   = TmoUsW'(tmo_q) * US_PER_MS;
	assign dl_sum   = {1'b0, now_q} + (NowW+1)'(tmo_us);
	assign deadline = dl_sum[NowW] ? '1 : dl_sum[NowW-1:0];

	// quotient would not fit 32 bits
	assign sat = elapsed_q >= {{(NowW-IvW-ElapsLoW){1'b0}}, iv_eff, {ElapsLoW{1'b0}}};

	assign add     = !past_q ? '0 : (sat_q ? '1 : quo);
	assign acc_sum = {1'b0, stored_q} + {1'b0, add};

	assign want_q16 = {want_q, {FracW{1'b0}}};
	assign spend    = (want_q16 < stored_q) ? want_q16 : stored_q;
	assign fresh    = want_q16 - spend;

	// next free time is never behind now here
	assign ahead    = nft_q - now_q;
	assign wait_sat = ahead[NowW-1] ? '1 : ahead[WaitW-1:0];

	assign nft_sum = {1'b0, nft_q} + (NowW+1)'(push);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign fin_go    = (state_q == S_FIN) && (!resp_valid_q || resp.ready);
	assign div_start = (state_q == S_ACCR) && !sat;
	assign mul_start = (state_q == S_SPEND);

	tbrl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (elapsed_q[ElapsLoW +: IvW]),
		.low_bits (elapsed_q[ElapsLoW-1:0]),
		.divisor  (iv_eff),
		.quo      (quo),
		.stat     (div_stat)
	);

	tbrl_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.fresh  (fresh),
		.iv     (iv_eff),
		.push   (push),
		.stat   (mul_stat)
	);

	// sequencer and bucket state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			interval_q <= INTERVAL_RESET;
			max_q      <= '0;
			stored_q   <= '0;
			nft_q      <= '0;
			refused_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == REG_INTERVAL) begin
					interval_q <= cfg_data[IvW-1:0];
				end else if (cfg_idx == REG_MAX_PERMITS) begin
					max_q    <= cfg_data[PermW-1:0];
					stored_q <= cfg_data[PermW-1:0];
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						refused_q <= 1'b0;
						state_q   <= S_CHECK;
					end
				end
				S_CHECK: state_q <= S_DEC;
				S_DEC: begin
					// refusal looks at the next free time before any accrual
					priority if (action_q && (nft_q > deadline_q)) begin
						refused_q <= 1'b1;
						state_q   <= S_FIN;
					end else if (past_q) begin
						state_q <= S_ACCR;
					end else begin
						state_q <= S_UPD;
					end
				end
				S_ACCR: state_q <= sat ? S_UPD : S_DIV;
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (past_q) begin
						stored_q <= (acc_sum < {1'b0, max_q}) ? acc_sum[PermW-1:0] : max_q;
						nft_q    <= now_q;
					end
					state_q <= S_SPEND;
				end
				S_SPEND: state_q <= S_MUL;
				S_MUL: begin
					if (mul_stat.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						if (!refused_q) begin
							nft_q    <= nft_sum[NowW] ? '1 : nft_sum[NowW-1:0];
							stored_q <= stored_q - spend_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request context, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= req.action;
			now_q    <= req.now_us;
			want_q   <= req.permits;
			tmo_q    <= req.timeout_ms;
		end
		if (state_q == S_CHECK) begin
			deadline_q <= deadline;
			elapsed_q  <= now_q - nft_q;
			past_q     <= now_q > nft_q;
		end
		if (state_q == S_ACCR) begin
			sat_q <= sat;
		end
		if (state_q == S_SPEND) begin
			spend_q <= spend;
			wait_q  <= wait_sat;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_valid_q <= 1'b0;
		end else if (fin_go) begin
			resp_valid_q <= 1'b1;
		end else if (resp.ready) begin
			resp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			granted_q <= !refused_q;
			wait_us_q <= refused_q ? '0 : wait_q;
		end
	end

	assign resp.valid   = resp_valid_q;
	assign resp.granted = granted_q;
	assign resp.wait_us = wait_us_q;

	// a refusal never asks the caller to wait
	a_refuse_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(resp.valid && !resp.granted) |-> (resp.wait_us == '0))
		else $error("refused request carries a wait");

	// accrual always leaves the bucket at or below capacity
	a_accrue_capped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && past_q && !cfg_we) |=> (stored_q <= max_q))
		else $error("accrual left stored permits above capacity");

	// a grant never pulls the next free time back
	a_nft_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && !refused_q && !cfg_we) |=> (nft_q >= $past(nft_q)))
		else $error("next free time moved backwards on grant");

	// the serial units never run together
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_stat.busy && mul_stat.busy))
		else $error("divider and multiplier busy at once");

	// a refused request leaves the bucket untouched
	a_refuse_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && refused_q && !cfg_we) |=> (nft_q == $past(nft_q) && stored_q == $past(stored_q)))
		else $error("refused request changed bucket state");

endmodule

@@ verif/token_bucket_rate_limiter_tb.sv @@
// Self-checking testbench of the token bucket rate limiter: directed and random requests.
`timescale 1ns / 1ps

module token_bucket_rate_limiter_tb;
	import tbrl_pkg::*;

	localparam bit ACQUIRE = 1'b0;
	localparam bit TRY     = 1'b1;

	// Any index above the capacity register must be ignored by the limiter.
	localparam logic [CfgIdxW-1:0] REG_SPARE = REG_MAX_PERMITS + CfgIdxW'(1);

	localparam logic [NowW-1:0] WAIT_CEIL   = {1'b0, {WaitW{1'b1}}};
	localparam int              QUIET_LIMIT = 4000;  // cycles with no handshake at all
	localparam int              LONG_HOLD   = 400;   // response hold-off, in cycles
	localparam int              DRAIN_TAIL  = 100;   // cycles watched after the last result

	typedef struct {
		bit                action;
		bit [NowW-1:0]     now_us;
		bit [ReqPermW-1:0] permits;
		bit [TmoW-1:0]     timeout_ms;
	} bucket_req_t;

	typedef struct {
		bit             granted;
		bit [WaitW-1:0] wait_us;
	} grant_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_idx;
	logic [CfgDataW-1:0] cfg_data;

	tbrl_req_if  req_ch ();
	tbrl_resp_if resp_ch ();

	token_bucket_rate_limiter DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req_ch.sink),
		.resp     (resp_ch.source)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Bucket predictor: its own copy of registers and state
	// ------------------------------------------------------------------
	bit [IvW-1:0]   iv_q8;
	bit [PermW-1:0] cap_q16;
	bit [NowW-1:0]  free_at_us;
	bit [PermW-1:0] tokens_q16;

	function automatic void bucket_write(input logic [CfgIdxW-1:0] idx,
			input logic [CfgDataW-1:0] val);
		if (idx == REG_INTERVAL) begin
			iv_q8 = val[IvW-1:0];
		end else if (idx == REG_MAX_PERMITS) begin
			// capacity write refills the bucket
			cap_q16    = val[PermW-1:0];
			tokens_q16 = cap_q16;
		end
	endfunction

	// Serves one request against the bucket and returns the grant it earns.
	function automatic grant_t bucket_serve(input bucket_req_t r);
		bit [IvW-1:0]    iv;
		bit [NowW-1:0]   tmo_us;
		bit [NowW:0]     wide_sum;
		bit [NowW-1:0]   deadline;
		bit [NowW-1:0]   elapsed;
		bit [127:0]      num;
		bit [127:0]      prod;
		bit [PermW-1:0]  fresh_q16;
		bit [PermW:0]    filled;
		bit [PermW-1:0]  want;
		bit [PermW-1:0]  spend;
		bit [PermW-1:0]  gained;
		bit [NowW-1:0]   push;
		bit [NowW-1:0]   lag;
		grant_t          g;
		iv     = (iv_q8 == '0) ? IvW'(1) : iv_q8;   // zero interval means the finest step
		want   = {r.permits, 16'h0};
		tmo_us = NowW'(r.timeout_ms) * NowW'(1000);

		// try-acquire: refused against the free time seen before accrual
		if (r.action == TRY) begin
			wide_sum = {1'b0, r.now_us} + {1'b0, tmo_us};
			deadline = wide_sum[NowW] ? '1 : wide_sum[NowW-1:0];
			if (free_at_us > deadline) begin
				g.granted = 1'b0;
				g.wait_us = '0;
				return g;
			end
		end

		// accrual only when time has moved past the free time
		if (r.now_us > free_at_us) begin
			elapsed = r.now_us - free_at_us;
			if (elapsed >= {16'h0, iv, 8'h0}) begin
				gained = '1;
			end else begin
				num    = {40'h0, elapsed, 24'h0};
				gained = PermW'(num / {88'h0, iv});
			end
			filled     = {1'b0, tokens_q16} + {1'b0, gained};
			tokens_q16 = (filled < {1'b0, cap_q16}) ? filled[PermW-1:0] : cap_q16;
			free_at_us = r.now_us;
		end

		lag = (free_at_us > r.now_us) ? free_at_us - r.now_us : '0;
		if (lag > WAIT_CEIL)
			lag = WAIT_CEIL;

		// stored permits first, the rest is borrowed against future time
		spend     = (want < tokens_q16) ? want : tokens_q16;
		fresh_q16 = want - spend;
		prod      = {96'h0, fresh_q16} * {88'h0, iv};
		push      = prod[87:24];
		wide_sum  = {1'b0, free_at_us} + {1'b0, push};
		free_at_us = wide_sum[NowW] ? '1 : wide_sum[NowW-1:0];
		tokens_q16 = tokens_q16 - spend;

		g.granted = 1'b1;
		g.wait_us = lag[WaitW-1:0];
		return g;
	endfunction

	// ------------------------------------------------------------------
	// Shared bookkeeping
	// ------------------------------------------------------------------
	bucket_req_t pending[$];       // requests not yet offered
	grant_t      grant_fifo[$];    // grants owed by the limiter, oldest first
	bucket_req_t head;
	int          reqs_queued   = 0;
	int          reqs_accepted = 0;
	int          errors        = 0;
	bit          req_taken     = 1'b0;
	int          idle_pct      = 0;   // chance of starting an idle burst, both sides
	int          send_gap      = 0;
	int          stall_left    = 0;
	int          hold_asks     = 0;
	int          hold_seen     = 0;
	int          hold_left     = 0;
	int          quiet         = 0;
	bit [NowW-1:0] clock_us    = '0;  // running time of the random requests
	bit [NowW-1:0] tick_us     = 64'd1;

	// ------------------------------------------------------------------
	// Request driver: offers the pending requests, with random gaps
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && !req_taken) begin
				// request still waiting to be taken: hold it
			end else if (send_gap != 0) begin
				send_gap--;
				req_ch.valid <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				send_gap = $urandom_range(0, 12);
				req_ch.valid <= 1'b0;
			end else if (pending.size() != 0) begin
				head = pending.pop_front();
				req_ch.valid      <= 1'b1;
				req_ch.action     <= head.action;
				req_ch.now_us     <= head.now_us;
				req_ch.permits    <= head.permits;
				req_ch.timeout_ms <= head.timeout_ms;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Response ready: random stalls, plus a long hold-off on demand
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				hold_left--;
				resp_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				resp_ch.ready <= 1'b0;
			end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(0, 12);
				resp_ch.ready <= 1'b0;
			end else begin
				resp_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: predicts on every accepted request, checks every result
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		bucket_req_t taken;
		grant_t      owed;
		req_taken = 1'b0;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				taken.action     = req_ch.action;
				taken.now_us     = req_ch.now_us;
				taken.permits    = req_ch.permits;
				taken.timeout_ms = req_ch.timeout_ms;
				grant_fifo.push_back(bucket_serve(taken));
				req_taken = 1'b1;
				reqs_accepted++;
			end
			if (resp_ch.valid && resp_ch.ready) begin
				if (grant_fifo.size() == 0) begin
					$display("%0t: unexpected result granted %0b wait_us %0d", $time,
						resp_ch.granted, resp_ch.wait_us);
					errors++;
				end else begin
					owed = grant_fifo.pop_front();
					if (resp_ch.granted !== owed.granted) begin
						$display("%0t: granted expected %0b actual %0b", $time,
							owed.granted, resp_ch.granted);
						errors++;
					end
					if (resp_ch.wait_us !== owed.wait_us) begin
						$display("%0t: wait_us expected %0d actual %0d", $time,
							owed.wait_us, resp_ch.wait_us);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog: a long run of cycles with no handshake on either side is a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (resp_ch.valid && resp_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, quiet);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_request(input bit act, input bit [NowW-1:0] now,
			input bit [ReqPermW-1:0] n, input bit [TmoW-1:0] tmo);
		bucket_req_t r;
		r.action     = act;
		r.now_us     = now;
		r.permits    = n;
		r.timeout_ms = tmo;
		pending.push_back(r);
		reqs_queued++;
	endtask

	// Sender pause: every request taken and every grant returned.
	task automatic settle();
		while (reqs_accepted != reqs_queued || grant_fifo.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we   = 1'b1;
		cfg_idx  = idx;
		cfg_data = val;
		bucket_write(idx, val);
		@(negedge clk);
		cfg_we   = 1'b0;
	endtask

	// Moves the running time forward, stopping at the top of the range.
	task automatic advance(input bit [NowW-1:0] step);
		bit [NowW:0] sum;
		sum      = {1'b0, clock_us} + {1'b0, step};
		clock_us = sum[NowW] ? '1 : sum[NowW-1:0];
	endtask

	// One random request. Well-formed ones follow a running time scaled to the
	// permit interval; noisy ones land anywhere at or before it with raw fields.
	task automatic queue_random(input bit noisy);
		bit [63:0]       wide;
		bit [NowW-1:0]   now;
		bit [ReqPermW-1:0] n;
		bit [NowW-1:0]   tmo;
		wide = {$urandom, $urandom};
		if (noisy) begin
			now = clock_us - NowW'({1'b0, wide} % ({1'b0, clock_us} + 65'd1));
			queue_request(1'($urandom_range(0, 1)), now, ReqPermW'($urandom),
				TmoW'($urandom));
		end else begin
			now = clock_us;
			case ($urandom_range(0, 9))
				0: begin
					// same instant as the previous request
				end
				1, 2, 3, 4, 5: begin
					advance((tick_us * $urandom_range(0, 1500)) / 1000);
					now = clock_us;
				end
				6, 7: begin
					advance(tick_us * $urandom_range(1, 8));
					now = clock_us;
				end
				8: begin
					// long sleep: accrual can saturate and fill the bucket
					advance(NowW'(wide[39:0]));
					now = clock_us;
				end
				default: begin
					// caller's clock behind the previous request
					now = clock_us - NowW'($urandom_range(0, 1000)) * tick_us;
				end
			endcase
			case ($urandom_range(0, 9))
				0:       n = ReqPermW'($urandom);
				1:       n = '0;
				default: n = ReqPermW'($urandom_range(1, 3));
			endcase
			if ($urandom_range(0, 7) == 0)
				tmo = NowW'($urandom_range(0, 65535));
			else
				tmo = (tick_us / 1000) * $urandom_range(0, 3) + $urandom_range(0, 2);
			if (tmo > 65535)
				tmo = 65535;
			queue_request(1'($urandom_range(0, 1)), now, n, tmo[TmoW-1:0]);
		end
	endtask

	// One random phase at a fresh setting; returns once the limiter is idle.
	task automatic run_phase(input logic [CfgDataW-1:0] iv, input logic [CfgDataW-1:0] cap,
			input int count, input int noise_pct, input int gap_pct, input bit long_hold);
		write_reg(REG_INTERVAL, iv);
		write_reg(REG_MAX_PERMITS, cap);
		idle_pct = gap_pct;
		tick_us  = ((iv_q8 >> 8) == 0) ? 64'd1 : NowW'(iv_q8 >> 8);
		if (free_at_us > clock_us)
			clock_us = free_at_us;
		repeat (count)
			queue_random($urandom_range(0, 99) < noise_pct);
		// receiver backs off for a long hold-off once the phase is queued
		if (long_hold)
			hold_asks++;
		settle();
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		bit [NowW-1:0] t0;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_idx           = '0;
		cfg_data          = '0;
		req_ch.valid      = 1'b0;
		req_ch.action     = 1'b0;
		req_ch.now_us     = '0;
		req_ch.permits    = '0;
		req_ch.timeout_ms = '0;
		resp_ch.ready     = 1'b0;

		iv_q8      = INTERVAL_RESET;
		cap_q16    = '0;
		free_at_us = '0;
		tokens_q16 = '0;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		idle_pct = 15;

		// Reset setting: 1 s per permit, empty bucket of zero capacity.
		queue_request(ACQUIRE, 64'd0, 16'd0, 16'd0);       // time equal to free time
		queue_request(ACQUIRE, 64'd1000, 16'd1, 16'd0);    // whole permit borrowed
		queue_request(TRY, 64'd2000, 16'd1, 16'd0);        // refused, no state change
		queue_request(TRY, 64'd2000, 16'hFFFF, 16'd1000);  // inside timeout, huge borrow
		queue_request(ACQUIRE, 64'd5000, 16'd0, 16'd0);
		settle();

		// 1 us per permit, three in the bucket; upper data bits of the
		// capacity write fall outside the register, the spare index is ignored.
		write_reg(REG_INTERVAL, CfgDataW'(256));
		write_reg(REG_MAX_PERMITS, 40'hFF_0003_0000);
		write_reg(REG_SPARE, 40'h00_0001_2345);
		t0 = free_at_us + 64'd10;
		queue_request(ACQUIRE, t0, 16'd2, 16'd0);          // from stored permits
		queue_request(ACQUIRE, t0, 16'd3, 16'd0);          // one stored, two borrowed
		queue_request(ACQUIRE, t0, 16'd0, 16'd0);          // sees the borrowed wait
		queue_request(TRY, t0 + 64'd1, 16'd1, 16'd0);      // one short: refused
		queue_request(TRY, t0 + 64'd2, 16'd1, 16'd0);      // exactly on time: granted
		queue_request(ACQUIRE, t0 - 64'd5, 16'd1, 16'd0);  // time went backwards
		queue_request(ACQUIRE, t0 + 64'd100, 16'd0, 16'd0);
		settle();

		// Zero interval and full capacity.
		write_reg(REG_INTERVAL, '0);
		write_reg(REG_MAX_PERMITS, CfgDataW'(32'hFFFF_FFFF));
		t0 = free_at_us + 64'd1000;
		queue_request(ACQUIRE, t0, 16'hFFFF, 16'd0);
		queue_request(ACQUIRE, t0, 16'd1, 16'd0);
		queue_request(ACQUIRE, t0, 16'd5, 16'd0);
		settle();

		// Largest interval: a full borrow pushes the free time far out.
		write_reg(REG_INTERVAL, 40'hFF_FFFF_FFFF);
		t0 = free_at_us + 64'd7;
		queue_request(ACQUIRE, t0, 16'hFFFF, 16'd0);
		queue_request(TRY, t0, 16'd1, 16'hFFFF);
		queue_request(ACQUIRE, t0, 16'd0, 16'd0);
		settle();

		// Random phases across the register ranges.
		clock_us = free_at_us;
		run_phase(CfgDataW'(256000), CfgDataW'(5 << 16), 190, 10, 20, 1'b0);
		run_phase(CfgDataW'(256), '0, 190, 10, 0, 1'b0);
		run_phase('0, CfgDataW'(32'hFFFF_FFFF), 190, 10, 15, 1'b1);
		run_phase(40'hFF_FFFF_FFFF, CfgDataW'(1 << 16), 190, 10, 10, 1'b0);
		run_phase(CfgDataW'(INTERVAL_RESET), CfgDataW'(32'h0001_8000), 190, 10, 25, 1'b0);
		write_reg(CfgIdxW'($urandom_range(REG_SPARE, {CfgIdxW{1'b1}})),
			CfgDataW'({$urandom, $urandom}));
		run_phase(CfgDataW'({$urandom, $urandom}), CfgDataW'($urandom), 190, 35, 15, 1'b0);
		run_phase(CfgDataW'(1), '0, 190, 10, 10, 1'b0);
		run_phase(CfgDataW'(25600), CfgDataW'(100 << 16), 190, 10, 20, 1'b0);

		// Last part, no idling: times near the top of the 64-bit range.
		clock_us = {12'hFFF, 1'b0, 19'($urandom_range(0, 32'h7FFFF)), $urandom};
		run_phase(CfgDataW'(256000), CfgDataW'(10 << 16), 150, 10, 0, 1'b0);
		queue_request(TRY, 64'hFFFF_FFFF_FFFF_FFF0, 16'd1, 16'hFFFF);    // deadline overflow
		queue_request(ACQUIRE, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'd0); // free time saturates
		queue_request(ACQUIRE, 64'd0, 16'd1, 16'd0);                      // wait saturates
		queue_request(TRY, 64'd0, 16'd1, 16'hFFFF);                       // refused at the top
		settle();

		repeat (DRAIN_TAIL) @(negedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/tbrl_pkg.sv
rtl/core/tbrl_if.sv
rtl/core/tbrl_div.sv
rtl/core/tbrl_mul.sv
rtl/core/token_bucket_rate_limiter.sv
verif/token_bucket_rate_limiter_tb.sv
